FILE: rtl/slit_pkg.sv
// Shared types, constants and helpers for the segment/line intersection test.
package slit_pkg;

  // Fixed widths of the channel fields, and counts of coordinates and points
  localparam int FIELD_W    = 32;
  localparam int FUNC_W     = 2;
  localparam int VERDICT_W  = 2;
  localparam int NUM_COORDS = 8;
  localparam int NUM_PTS    = 4;

  // Point slots after ordering: A start/end, B start/end
  localparam int PT_A0 = 0;
  localparam int PT_A1 = 1;
  localparam int PT_B0 = 2;
  localparam int PT_B1 = 3;

  // Query modes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_SEG_SEG   = 2'd0,
    FUNC_LINE_SEG  = 2'd1,
    FUNC_LINE_LINE = 2'd2
  } func_e;

  // Result codes
  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_NONE    = 2'd0,
    VERDICT_POINT   = 2'd1,
    VERDICT_OVERLAP = 2'd2
  } verdict_e;

  // Sign of one cross product; neg is never set together with zero
  typedef struct packed {
    logic neg;
    logic zero;
  } sgn_t;

  // Orientation signs used by the classifier
  typedef struct packed {
    sgn_t par;  // dir A x dir B
    sgn_t u2;   // side of A end relative to B
    sgn_t u1;   // side of A start relative to B
    sgn_t t2;   // side of B end relative to A
    sgn_t t1;   // side of B start relative to A
  } orient_t;

  // Lexicographic compares between the ordered endpoints
  typedef struct packed {
    logic a0_lt_b0;
    logic b0_lt_a0;
    logic b1_lt_a0;
    logic a1_lt_b0;
    logic a1_lt_b1;
    logic b1_lt_a1;
  } lex_t;

  // Lexicographic less-than: x first, then y
  function automatic logic pt_less(input logic signed [FIELD_W-1:0] px,
                                   input logic signed [FIELD_W-1:0] py,
                                   input logic signed [FIELD_W-1:0] qx,
                                   input logic signed [FIELD_W-1:0] qy);
    logic lt;
    lt = (px < qx) || ((px == qx) && (py < qy));
    return lt;
  endfunction

endpackage

FILE: rtl/slit_in_if.sv
// Query channel: mode plus the endpoints of items A and B.
interface slit_in_if import slit_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic        [FUNC_W-1:0]  func;
  logic signed [FIELD_W-1:0] a_start_x;
  logic signed [FIELD_W-1:0] a_start_y;
  logic signed [FIELD_W-1:0] a_end_x;
  logic signed [FIELD_W-1:0] a_end_y;
  logic signed [FIELD_W-1:0] b_start_x;
  logic signed [FIELD_W-1:0] b_start_y;
  logic signed [FIELD_W-1:0] b_end_x;
  logic signed [FIELD_W-1:0] b_end_y;

  modport source (
    output valid, func, a_start_x, a_start_y, a_end_x, a_end_y,
           b_start_x, b_start_y, b_end_x, b_end_y,
    input  ready
  );
  modport sink (
    input  valid, func, a_start_x, a_start_y, a_end_x, a_end_y,
           b_start_x, b_start_y, b_end_x, b_end_y,
    output ready
  );
endinterface

FILE: rtl/slit_out_if.sv
// Result channel: intersection verdict.
interface slit_out_if import slit_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [VERDICT_W-1:0] verdict;

  modport source (
    output valid, verdict,
    input  ready
  );
  modport sink (
    input  valid, verdict,
    output ready
  );
endinterface

FILE: rtl/segment_line_intersection_test_core.sv
// Top level: segment/line intersection classifier, five-stage pipeline.
//
//   Channel  Dir  Payload                                        Accepted when
//   in_i     in   func, a/b start/end x/y (32 bit signed each)   valid && ready
//   out_o    out  verdict (0 none, 1 one point, 2 overlap)       valid && ready
//
// One item per cycle sustained while out_o is ready.
// The depth is set by the exact cross products: one stage forms the edge
// vectors, one the products of (COORD_WIDTH+1)-bit differences, one their signs.
// Reset clears only the valid bits of each stage; no clearing pass.
// Each stage holds its item under back-pressure and takes a new one when it
// is empty or drains, so bubbles fill while the output waits.
module segment_line_intersection_test_core import slit_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  slit_in_if.sink    in_i,
  slit_out_if.source out_o
);

  logic [NUM_COORDS-1:0][FIELD_W-1:0]  coord;
  logic                                ord_valid, ord_ready;
  logic [FUNC_W-1:0]                   ord_func;
  logic [NUM_PTS-1:0][COORD_WIDTH-1:0] ord_x, ord_y;
  logic                                crs_valid, crs_ready;
  logic [FUNC_W-1:0]                   crs_func;
  lex_t                                crs_lex;
  orient_t                             crs_orient;
  logic                                on_a0, on_a1, on_b0, on_b1, same_line;
  verdict_e                            verdict_d;
  logic [VERDICT_W-1:0]                verdict_q;
  logic                                v5_q;

  // Gather coordinates in point order
  assign coord[0] = in_i.a_start_x;
  assign coord[1] = in_i.a_start_y;
  assign coord[2] = in_i.a_end_x;
  assign coord[3] = in_i.a_end_y;
  assign coord[4] = in_i.b_start_x;
  assign coord[5] = in_i.b_start_y;
  assign coord[6] = in_i.b_end_x;
  assign coord[7] = in_i.b_end_y;

  slit_order #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_order (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .func_i  (in_i.func),
    .coord_i (coord),
    .valid_o (ord_valid),
    .ready_i (ord_ready),
    .func_o  (ord_func),
    .x_o     (ord_x),
    .y_o     (ord_y)
  );

  slit_cross #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_cross (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (ord_valid),
    .ready_o  (ord_ready),
    .func_i   (ord_func),
    .x_i      (ord_x),
    .y_i      (ord_y),
    .valid_o  (crs_valid),
    .ready_i  (crs_ready),
    .func_o   (crs_func),
    .lex_o    (crs_lex),
    .orient_o (crs_orient)
  );

  // Stage 5 logic: classify from signs and endpoint order
  always_comb begin
    on_a0 = crs_orient.u1.zero && !(crs_lex.a0_lt_b0 || crs_lex.b1_lt_a0);
    on_a1 = crs_orient.u2.zero && !(crs_lex.a1_lt_b0 || crs_lex.b1_lt_a1);
    on_b0 = crs_orient.t1.zero && !(crs_lex.b0_lt_a0 || crs_lex.a1_lt_b0);
    on_b1 = crs_orient.t2.zero && !(crs_lex.b1_lt_a0 || crs_lex.a1_lt_b1);
    same_line = crs_orient.par.zero && crs_orient.t2.zero && crs_orient.u1.zero;
    verdict_d = VERDICT_NONE;
    case (crs_func)
      FUNC_SEG_SEG: begin
        if (crs_orient.t1 == crs_orient.t2) begin
          if (crs_orient.t1.zero && (on_a0 || on_a1 || on_b0 || on_b1)) begin
            verdict_d = VERDICT_OVERLAP;
          end
        end else if (crs_orient.u1 != crs_orient.u2) begin
          verdict_d = VERDICT_POINT;
        end
      end
      FUNC_LINE_SEG: begin
        if (same_line) begin
          verdict_d = VERDICT_OVERLAP;
        end else if (!crs_orient.par.zero && (crs_orient.t1 != crs_orient.t2)) begin
          verdict_d = VERDICT_POINT;
        end
      end
      FUNC_LINE_LINE: begin
        if (same_line) begin
          verdict_d = VERDICT_OVERLAP;
        end else if (!crs_orient.par.zero) begin
          verdict_d = VERDICT_POINT;
        end
      end
      default: verdict_d = VERDICT_NONE;
    endcase
  end

  // Output register
  assign crs_ready = !v5_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (crs_ready) begin
      v5_q <= crs_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (crs_ready && crs_valid) begin
      verdict_q <= verdict_d;
    end
  end

  assign out_o.valid   = v5_q;
  assign out_o.verdict = verdict_q;

  // Parallel directions never yield a single crossing point in any mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    crs_valid && crs_orient.par.zero |-> verdict_d != VERDICT_POINT)
    else $error("slit core: single point reported for parallel items");

endmodule

FILE: rtl/slit_order.sv
// Stage 1: coordinate truncation and lexicographic ordering of each item's endpoints.
module slit_order import slit_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     valid_i,
  output logic                                     ready_o,
  input  logic [FUNC_W-1:0]                        func_i,
  input  logic [NUM_COORDS-1:0][FIELD_W-1:0]       coord_i,
  output logic                                     valid_o,
  input  logic                                     ready_i,
  output logic [FUNC_W-1:0]                        func_o,
  output logic [NUM_PTS-1:0][COORD_WIDTH-1:0]      x_o,
  output logic [NUM_PTS-1:0][COORD_WIDTH-1:0]      y_o
);

  logic [NUM_PTS-1:0][COORD_WIDTH-1:0] raw_x, raw_y;
  logic [NUM_PTS-1:0][COORD_WIDTH-1:0] x_d, y_d, x_q, y_q;
  logic [FUNC_W-1:0]                   func_q;
  logic                                swap_a, swap_b;
  logic                                valid_q;
  logic                                load;

  // Keep the low COORD_WIDTH bits of each field, then order A and B
  always_comb begin
    for (int k = 0; k < NUM_PTS; k++) begin
      raw_x[k] = coord_i[2*k][COORD_WIDTH-1:0];
      raw_y[k] = coord_i[2*k+1][COORD_WIDTH-1:0];
    end
    swap_a = pt_less(FIELD_W'($signed(raw_x[PT_A1])), FIELD_W'($signed(raw_y[PT_A1])),
                     FIELD_W'($signed(raw_x[PT_A0])), FIELD_W'($signed(raw_y[PT_A0])));
    swap_b = pt_less(FIELD_W'($signed(raw_x[PT_B1])), FIELD_W'($signed(raw_y[PT_B1])),
                     FIELD_W'($signed(raw_x[PT_B0])), FIELD_W'($signed(raw_y[PT_B0])));
    x_d[PT_A0] = swap_a ? raw_x[PT_A1] : raw_x[PT_A0];
    y_d[PT_A0] = swap_a ? raw_y[PT_A1] : raw_y[PT_A0];
    x_d[PT_A1] = swap_a ? raw_x[PT_A0] : raw_x[PT_A1];
    y_d[PT_A1] = swap_a ? raw_y[PT_A0] : raw_y[PT_A1];
    x_d[PT_B0] = swap_b ? raw_x[PT_B1] : raw_x[PT_B0];
    y_d[PT_B0] = swap_b ? raw_y[PT_B1] : raw_y[PT_B0];
    x_d[PT_B1] = swap_b ? raw_x[PT_B0] : raw_x[PT_B1];
    y_d[PT_B1] = swap_b ? raw_y[PT_B0] : raw_y[PT_B1];
  end

  // Stage handshake: take an item when empty or when the next stage drains
  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      func_q <= func_i;
      x_q    <= x_d;
      y_q    <= y_d;
    end
  end

  assign valid_o = valid_q;
  assign func_o  = func_q;
  assign x_o     = x_q;
  assign y_o     = y_q;

endmodule

FILE: rtl/slit_cross.sv
// Stages 2-4: edge vectors and endpoint compares, cross-product terms, orientation signs.
module slit_cross import slit_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  logic [FUNC_W-1:0]                   func_i,
  input  logic [NUM_PTS-1:0][COORD_WIDTH-1:0] x_i,
  input  logic [NUM_PTS-1:0][COORD_WIDTH-1:0] y_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output logic [FUNC_W-1:0]                   func_o,
  output lex_t                                lex_o,
  output orient_t                             orient_o
);

  localparam int DW     = COORD_WIDTH + 1;  // difference of two coordinates
  localparam int PW     = 2 * DW;           // product of two differences
  localparam int XW     = PW + 1;           // difference of two products
  localparam int NDIFF  = 6;
  localparam int NCROSS = 5;

  // Vectors: dA=A1-A0, dB=B1-B0, B0-A0, B1-A0, A0-B0, A1-B0
  localparam int DiffP[NDIFF] = '{PT_A1, PT_B1, PT_B0, PT_B1, PT_A0, PT_A1};
  localparam int DiffQ[NDIFF] = '{PT_A0, PT_B0, PT_A0, PT_A0, PT_B0, PT_B0};
  // Cross products in order t1, t2, u1, u2, par
  localparam int CrossU[NCROSS] = '{0, 0, 1, 1, 0};
  localparam int CrossV[NCROSS] = '{2, 3, 4, 5, 1};

  logic                      rdy2, rdy3, rdy4;
  logic                      v2_q, v3_q, v4_q;
  logic [FUNC_W-1:0]         func2_q, func3_q, func4_q;
  lex_t                      lex_d, lex2_q, lex3_q, lex4_q;
  orient_t                   orient_d, orient_q;

  logic signed [DW-1:0]      dx_d [NDIFF];
  logic signed [DW-1:0]      dy_d [NDIFF];
  logic signed [DW-1:0]      dx_q [NDIFF];
  logic signed [DW-1:0]      dy_q [NDIFF];
  logic signed [PW-1:0]      pl_d [NCROSS];
  logic signed [PW-1:0]      pr_d [NCROSS];
  logic signed [PW-1:0]      pl_q [NCROSS];
  logic signed [PW-1:0]      pr_q [NCROSS];
  logic signed [XW-1:0]      cd   [NCROSS];
  sgn_t                      sg   [NCROSS];
  logic signed [FIELD_W-1:0] ex   [NUM_PTS];
  logic signed [FIELD_W-1:0] ey   [NUM_PTS];

  // Per-stage back-pressure
  assign rdy4    = !v4_q || ready_i;
  assign rdy3    = !v3_q || rdy4;
  assign rdy2    = !v2_q || rdy3;
  assign ready_o = rdy2;

  // Stage 2 logic: edge vectors and lexicographic compares
  always_comb begin
    for (int i = 0; i < NDIFF; i++) begin
      dx_d[i] = DW'($signed(x_i[DiffP[i]])) - DW'($signed(x_i[DiffQ[i]]));
      dy_d[i] = DW'($signed(y_i[DiffP[i]])) - DW'($signed(y_i[DiffQ[i]]));
    end
    for (int k = 0; k < NUM_PTS; k++) begin
      ex[k] = FIELD_W'($signed(x_i[k]));
      ey[k] = FIELD_W'($signed(y_i[k]));
    end
    lex_d.a0_lt_b0 = pt_less(ex[PT_A0], ey[PT_A0], ex[PT_B0], ey[PT_B0]);
    lex_d.b0_lt_a0 = pt_less(ex[PT_B0], ey[PT_B0], ex[PT_A0], ey[PT_A0]);
    lex_d.b1_lt_a0 = pt_less(ex[PT_B1], ey[PT_B1], ex[PT_A0], ey[PT_A0]);
    lex_d.a1_lt_b0 = pt_less(ex[PT_A1], ey[PT_A1], ex[PT_B0], ey[PT_B0]);
    lex_d.a1_lt_b1 = pt_less(ex[PT_A1], ey[PT_A1], ex[PT_B1], ey[PT_B1]);
    lex_d.b1_lt_a1 = pt_less(ex[PT_B1], ey[PT_B1], ex[PT_A1], ey[PT_A1]);
  end

  // Stage 3 logic: the two terms of each cross product u.x*v.y - u.y*v.x
  always_comb begin
    for (int j = 0; j < NCROSS; j++) begin
      pl_d[j] = dx_q[CrossU[j]] * dy_q[CrossV[j]];
      pr_d[j] = dy_q[CrossU[j]] * dx_q[CrossV[j]];
    end
  end

  // Stage 4 logic: subtract and take the sign
  always_comb begin
    for (int j = 0; j < NCROSS; j++) begin
      cd[j]      = XW'(pl_q[j]) - XW'(pr_q[j]);
      sg[j].neg  = cd[j][XW-1];
      sg[j].zero = (cd[j] == '0);
    end
    orient_d.t1  = sg[0];
    orient_d.t2  = sg[1];
    orient_d.u1  = sg[2];
    orient_d.u2  = sg[3];
    orient_d.par = sg[4];
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy2) v2_q <= valid_i;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (rdy2 && valid_i) begin
      func2_q <= func_i;
      lex2_q  <= lex_d;
      dx_q    <= dx_d;
      dy_q    <= dy_d;
    end
    if (rdy3 && v2_q) begin
      func3_q <= func2_q;
      lex3_q  <= lex2_q;
      pl_q    <= pl_d;
      pr_q    <= pr_d;
    end
    if (rdy4 && v3_q) begin
      func4_q  <= func3_q;
      lex4_q   <= lex3_q;
      orient_q <= orient_d;
    end
  end

  assign valid_o  = v4_q;
  assign func_o   = func4_q;
  assign lex_o    = lex4_q;
  assign orient_o = orient_q;

  // With parallel directions, B start on line A puts B end there too
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && orient_q.par.zero && orient_q.t1.zero |-> orient_q.t2.zero)
    else $error("slit_cross: t2 not collinear although par and t1 are");

  // Same identity seen from B: u2 - u1 equals minus par
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && orient_q.par.zero && orient_q.u1.zero |-> orient_q.u2.zero)
    else $error("slit_cross: u2 not collinear although par and u1 are");

  // A stalled result in the last stage holds its signs and compares
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && !ready_i |=> v4_q && $stable(orient_q) && $stable(lex4_q))
    else $error("slit_cross: stalled item changed");

endmodule

FILE: tb/sv/segment_line_intersection_checker.sv
// Checker: watches both channels, predicts each verdict and compares in order.
`timescale 1ns / 100ps

module segment_line_intersection_checker import slit_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  slit_in_if   query_i,
  slit_out_if  verdict_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   n_none_o,
  output int   n_point_o,
  output int   n_overlap_o
);

  // Wide enough that every cross product of coordinate differences is exact
  localparam int WIDE_W = 2 * FIELD_W + 6;

  typedef logic signed [WIDE_W-1:0] wide_t;

  typedef struct packed {
    wide_t x;
    wide_t y;
  } point_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [31:0] seq;
  } pending_verdict_t;

  pending_verdict_t verdicts_due[$];
  pending_verdict_t oldest;
  logic [31:0]      query_seq;

  // Sign-extend a coordinate from COORD_WIDTH bits, upper field bits ignored
  function automatic wide_t widen(input logic [FIELD_W-1:0] raw);
    wide_t v;
    v = '0;
    v[COORD_WIDTH-1:0] = raw[COORD_WIDTH-1:0];
    if (raw[COORD_WIDTH-1]) begin
      v[WIDE_W-1:COORD_WIDTH] = '1;
    end
    return v;
  endfunction

  function automatic point_t diff(input point_t p, input point_t q);
    point_t r;
    r.x = p.x - q.x;
    r.y = p.y - q.y;
    return r;
  endfunction

  // Sign of u x v: -1, 0 or 1
  function automatic int cross_sign(input point_t u, input point_t v);
    wide_t d;
    d = u.x * v.y - u.y * v.x;
    return (d == 0) ? 0 : ((d < 0) ? -1 : 1);
  endfunction

  function automatic int orient(input point_t o, input point_t p, input point_t q);
    return cross_sign(diff(p, o), diff(q, o));
  endfunction

  // Lexicographic order: x first, then y
  function automatic logic lex_less(input point_t a, input point_t b);
    wide_t ax, ay, bx, by;
    ax = a.x;
    ay = a.y;
    bx = b.x;
    by = b.y;
    return (ax < bx) || ((ax == bx) && (ay < by));
  endfunction

  function automatic logic on_seg(input point_t p, input point_t s0, input point_t s1);
    return (orient(s0, s1, p) == 0) && !(lex_less(p, s0) || lex_less(s1, p));
  endfunction

  function automatic logic dirs_parallel(input point_t l0, input point_t l1,
                                         input point_t m0, input point_t m1);
    return cross_sign(diff(l1, l0), diff(m1, m0)) == 0;
  endfunction

  function automatic logic same_line(input point_t l0, input point_t l1,
                                     input point_t m0, input point_t m1);
    return dirs_parallel(l0, l1, m0, m1)
        && (cross_sign(diff(l0, l1), diff(l0, m1)) == 0)
        && (cross_sign(diff(m1, m0), diff(m1, l0)) == 0);
  endfunction

  // Expected verdict for one query
  function automatic verdict_e classify_pair(
    input logic [FUNC_W-1:0]  f,
    input logic [FIELD_W-1:0] ax, ay, aex, aey, bx, by, bex, bey
  );
    point_t   a0, a1, b0, b1, tmp;
    verdict_e v;
    int       t1, t2;
    a0.x = widen(ax);
    a0.y = widen(ay);
    a1.x = widen(aex);
    a1.y = widen(aey);
    b0.x = widen(bx);
    b0.y = widen(by);
    b1.x = widen(bex);
    b1.y = widen(bey);
    // put each item's endpoints in lexicographic order
    if (lex_less(a1, a0)) begin
      tmp = a0;
      a0  = a1;
      a1  = tmp;
    end
    if (lex_less(b1, b0)) begin
      tmp = b0;
      b0  = b1;
      b1  = tmp;
    end
    v = VERDICT_NONE;
    case (f)
      FUNC_SEG_SEG: begin
        t1 = orient(a0, a1, b0);
        t2 = orient(a0, a1, b1);
        if (t1 == t2) begin
          // collinear: overlap (or shared endpoint) if any endpoint lies on the other
          if (t1 == 0 && (on_seg(a0, b0, b1) || on_seg(a1, b0, b1) ||
                          on_seg(b0, a0, a1) || on_seg(b1, a0, a1))) begin
            v = VERDICT_OVERLAP;
          end
        end else if (orient(b0, b1, a0) != orient(b0, b1, a1)) begin
          v = VERDICT_POINT;
        end
      end
      FUNC_LINE_SEG: begin
        if (same_line(a0, a1, b0, b1)) begin
          v = VERDICT_OVERLAP;
        end else if (!dirs_parallel(a0, a1, b0, b1) &&
                     orient(a0, a1, b0) != orient(a0, a1, b1)) begin
          v = VERDICT_POINT;
        end
      end
      FUNC_LINE_LINE: begin
        if (same_line(a0, a1, b0, b1)) begin
          v = VERDICT_OVERLAP;
        end else if (!dirs_parallel(a0, a1, b0, b1)) begin
          v = VERDICT_POINT;
        end
      end
      default: v = VERDICT_NONE;
    endcase
    return v;
  endfunction

  // Track accepted queries and compare each result with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      verdicts_due.delete();
      query_seq    = '0;
      fail_count_o = 0;
      pending_o    = 0;
      n_none_o     = 0;
      n_point_o    = 0;
      n_overlap_o  = 0;
    end else begin
      if (query_i.valid && query_i.ready) begin
        oldest.verdict = classify_pair(query_i.func,
                                       query_i.a_start_x, query_i.a_start_y,
                                       query_i.a_end_x, query_i.a_end_y,
                                       query_i.b_start_x, query_i.b_start_y,
                                       query_i.b_end_x, query_i.b_end_y);
        oldest.seq = query_seq;
        verdicts_due = {verdicts_due, oldest};
        query_seq = query_seq + 1;
      end
      if (verdict_i.valid && verdict_i.ready) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: unexpected verdict %0d with no query outstanding",
                   $time, verdict_i.verdict);
          fail_count_o = fail_count_o + 1;
        end else begin
          oldest = verdicts_due.pop_front();
          if (verdict_i.verdict !== oldest.verdict) begin
            $display("%0t: verdict mismatch on query %0d: expected %0d, actual %0d",
                     $time, oldest.seq, oldest.verdict, verdict_i.verdict);
            fail_count_o = fail_count_o + 1;
          end
          case (oldest.verdict)
            VERDICT_POINT:   n_point_o   = n_point_o + 1;
            VERDICT_OVERLAP: n_overlap_o = n_overlap_o + 1;
            default:         n_none_o    = n_none_o + 1;
          endcase
        end
      end
      pending_o = verdicts_due.size();
    end
  end

endmodule

FILE: tb/sv/segment_line_intersection_test_core_tb.sv
// Testbench top: clock, reset, query stimulus, result back-pressure and verdict.
`timescale 1ns / 100ps

module segment_line_intersection_test_core_tb;
  import slit_pkg::*;

  localparam int                 NUM_RANDOM  = 1800;
  localparam int                 IDLE_LIMIT  = 4000;
  localparam int                 DRAIN_TICKS = 12;
  localparam logic [FUNC_W-1:0]  FUNC_UNUSED = 2'd3;
  localparam logic [FIELD_W-1:0] CMAX        = 32'h7fff_ffff;
  localparam logic [FIELD_W-1:0] CMIN        = 32'h8000_0000;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [FIELD_W-1:0] a_start_x;
    logic [FIELD_W-1:0] a_start_y;
    logic [FIELD_W-1:0] a_end_x;
    logic [FIELD_W-1:0] a_end_y;
    logic [FIELD_W-1:0] b_start_x;
    logic [FIELD_W-1:0] b_start_y;
    logic [FIELD_W-1:0] b_end_x;
    logic [FIELD_W-1:0] b_end_y;
  } query_t;

  logic clk_i;
  logic rst_ni;
  logic idle_on;
  int   fail_count;
  int   pending;
  int   n_none, n_point, n_overlap;
  int   func_count [4];
  int   quiet_cycles;

  slit_in_if  query_if ();
  slit_out_if verdict_if ();

  segment_line_intersection_test_core #(
    .COORD_WIDTH(32)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (query_if),
    .out_o (verdict_if)
  );

  segment_line_intersection_checker #(
    .COORD_WIDTH(32)
  ) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .query_i     (query_if),
    .verdict_i   (verdict_if),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .n_none_o    (n_none),
    .n_point_o   (n_point),
    .n_overlap_o (n_overlap)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic query_t make_query(
    input logic [FUNC_W-1:0]  f,
    input logic [FIELD_W-1:0] ax, ay, aex, aey, bx, by, bex, bey
  );
    query_t q;
    q = '{f, ax, ay, aex, aey, bx, by, bex, bey};
    return q;
  endfunction

  // kind 0: small, 1: full range, 2: edge values
  function automatic logic [FIELD_W-1:0] rand_coord(input int kind);
    logic [FIELD_W-1:0] c;
    case (kind)
      0: c = $urandom_range(0, 16) - 8;
      1: c = $urandom();
      default: begin
        case ($urandom_range(0, 6))
          0: c = CMAX;
          1: c = CMIN;
          2: c = 0;
          3: c = -1;
          4: c = 1;
          5: c = CMAX - 1;
          default: c = CMIN + 1;
        endcase
      end
    endcase
    return c;
  endfunction

  // Random query, biased toward collinear, parallel, touching and degenerate pairs
  function automatic query_t rand_query();
    logic [FIELD_W-1:0] c [8];
    int                 shape, kind, px, py, dx, dy, ox, oy, k, src, dst;
    logic [FUNC_W-1:0]  f;
    shape = $urandom_range(0, 9);
    kind  = (shape == 3) ? 1 : (shape == 4) ? 2 : (shape >= 5) ? $urandom_range(0, 2) : 0;
    for (int i = 0; i < 8; i++) begin
      c[i] = rand_coord(shape == 9 ? $urandom_range(0, 2) : kind);
    end
    case (shape)
      5: begin
        // four points on one line
        px = ($urandom_range(0, 16) - 8) <<< $urandom_range(0, 24);
        py = ($urandom_range(0, 16) - 8) <<< $urandom_range(0, 24);
        dx = ($urandom_range(0, 8) - 4) <<< $urandom_range(0, 20);
        dy = ($urandom_range(0, 8) - 4) <<< $urandom_range(0, 20);
        for (int i = 0; i < 4; i++) begin
          k        = $urandom_range(0, 8) - 4;
          c[2*i]   = px + k * dx;
          c[2*i+1] = py + k * dy;
        end
      end
      6: begin
        // B is A shifted
        ox   = $urandom_range(0, 6) - 3;
        oy   = $urandom_range(0, 6) - 3;
        c[4] = c[0] + ox;
        c[5] = c[1] + oy;
        c[6] = c[2] + ox;
        c[7] = c[3] + oy;
      end
      7: begin
        // one endpoint of B copied from A
        src      = $urandom_range(0, 1);
        dst      = $urandom_range(2, 3);
        c[2*dst]   = c[2*src];
        c[2*dst+1] = c[2*src+1];
      end
      8: begin
        // zero-length A, B or both
        k = $urandom_range(1, 3);
        if (k[0]) begin
          c[2] = c[0];
          c[3] = c[1];
        end
        if (k[1]) begin
          c[6] = c[4];
          c[7] = c[5];
        end
      end
      default: ;
    endcase
    f = ($urandom_range(0, 15) == 0) ? FUNC_UNUSED : func_e'($urandom_range(0, 2));
    return make_query(f, c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
  endfunction

  // Present one query and hold it until accepted
  task automatic send_query(input query_t q);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      query_if.valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    query_if.valid     = 1'b1;
    query_if.func      = q.func;
    query_if.a_start_x = q.a_start_x;
    query_if.a_start_y = q.a_start_y;
    query_if.a_end_x   = q.a_end_x;
    query_if.a_end_y   = q.a_end_y;
    query_if.b_start_x = q.b_start_x;
    query_if.b_start_y = q.b_start_y;
    query_if.b_end_x   = q.b_end_x;
    query_if.b_end_y   = q.b_end_y;
    do @(posedge clk_i); while (!(query_if.valid && query_if.ready));
    func_count[q.func] = func_count[q.func] + 1;
    @(negedge clk_i);
  endtask

  // Stop sending until every outstanding verdict has come back
  task automatic wait_for_results();
    query_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Result-side stalls in random bursts
  initial begin
    verdict_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        verdict_if.ready = 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
      end
      verdict_if.ready = 1'b1;
    end
  end

  // Watchdog: ends the run if no item moves on either channel for too long
  initial begin
    quiet_cycles = 0;
    @(posedge rst_ni);
    while (quiet_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((query_if.valid && query_if.ready) || (verdict_if.valid && verdict_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
    end
    $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // Stimulus
  initial begin
    rst_ni             = 1'b0;
    idle_on            = 1'b1;
    query_if.valid     = 1'b0;
    query_if.func      = '0;
    query_if.a_start_x = '0;
    query_if.a_start_y = '0;
    query_if.a_end_x   = '0;
    query_if.a_end_y   = '0;
    query_if.b_start_x = '0;
    query_if.b_start_y = '0;
    query_if.b_end_x   = '0;
    query_if.b_end_y   = '0;
    for (int i = 0; i < 4; i++) func_count[i] = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // segment pairs: crossing, parallel, collinear overlap/touch/apart, T, reversed, miss
    send_query(make_query(FUNC_SEG_SEG, 0, 0, 10, 10, 0, 10, 10, 0));
    send_query(make_query(FUNC_SEG_SEG, 0, 0, 10, 0, 0, 5, 10, 5));
    send_query(make_query(FUNC_SEG_SEG, 0, 0, 10, 0, 5, 0, 15, 0));
    send_query(make_query(FUNC_SEG_SEG, 0, 0, 5, 5, 10, 10, 5, 5));
    send_query(make_query(FUNC_SEG_SEG, 0, 0, 1, 1, 3, 3, 5, 5));
    send_query(make_query(FUNC_SEG_SEG, 0, 0, 10, 0, 5, 0, 5, 5));
    send_query(make_query(FUNC_SEG_SEG, 10, 10, 0, 0, 10, 0, 0, 10));
    send_query(make_query(FUNC_SEG_SEG, 0, 0, 4, 0, 6, -1, 6, 1));
    // vertical collinear, ordered by y
    send_query(make_query(FUNC_SEG_SEG, 0, 5, 0, 0, 0, 3, 0, 9));
    // zero-length items
    send_query(make_query(FUNC_SEG_SEG, 3, 0, 3, 0, 0, 0, 10, 0));
    send_query(make_query(FUNC_SEG_SEG, 2, 2, 2, 2, 2, 2, 2, 2));
    send_query(make_query(FUNC_SEG_SEG, 1, 2, 1, 2, 3, 4, 3, 4));
    // line with segment
    send_query(make_query(FUNC_LINE_SEG, 0, 0, 1, 1, 10, 0, 0, 10));
    send_query(make_query(FUNC_LINE_SEG, 0, 0, 1, 0, 0, 1, 5, 1));
    send_query(make_query(FUNC_LINE_SEG, 0, 0, 1, 1, 5, 5, 9, 9));
    send_query(make_query(FUNC_LINE_SEG, 0, 0, 1, 0, 0, 1, 1, 5));
    send_query(make_query(FUNC_LINE_SEG, 0, 0, 1, 0, 3, 0, 3, 4));
    // line with line, then the unused mode
    send_query(make_query(FUNC_LINE_LINE, 0, 0, 1, 1, 0, 1, 1, 0));
    send_query(make_query(FUNC_LINE_LINE, 0, 0, 1, 1, 0, 1, 1, 2));
    send_query(make_query(FUNC_LINE_LINE, 0, 0, 1, 1, -3, -3, 7, 7));
    send_query(make_query(FUNC_LINE_LINE, 4, 4, 4, 4, 0, 0, 1, 0));
    send_query(make_query(FUNC_UNUSED, 0, 0, 10, 10, 0, 10, 10, 0));
    // coordinate extremes
    send_query(make_query(FUNC_SEG_SEG, CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN));
    send_query(make_query(FUNC_SEG_SEG, CMIN, 0, CMAX, 0, 0, CMIN, 0, CMAX));
    send_query(make_query(FUNC_LINE_LINE, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
    send_query(make_query(FUNC_LINE_SEG, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
    wait_for_results();

    // random queries; idling switched per phase, none in the last phases
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 150 == 0) begin
        idle_on = (n < NUM_RANDOM - 300) && ($urandom_range(0, 2) != 0);
      end
      if (n == NUM_RANDOM / 2) begin
        wait_for_results();
      end
      send_query(rand_query());
    end
    idle_on = 1'b0;
    wait_for_results();
    repeat (DRAIN_TICKS) @(negedge clk_i);

    $display("Queries: %0d seg-seg, %0d line-seg, %0d line-line, %0d unused mode",
             func_count[FUNC_SEG_SEG], func_count[FUNC_LINE_SEG],
             func_count[FUNC_LINE_LINE], func_count[FUNC_UNUSED]);
    $display("Verdicts checked: %0d none, %0d single point, %0d overlap; %0d errors",
             n_none, n_point, n_overlap, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: segment_line_intersection_test_core.f
rtl/slit_pkg.sv
rtl/slit_in_if.sv
rtl/slit_out_if.sv
rtl/slit_order.sv
rtl/slit_cross.sv
rtl/segment_line_intersection_test_core.sv
tb/sv/segment_line_intersection_checker.sv
tb/sv/segment_line_intersection_test_core_tb.sv
